/* rtl/pcoll_pkg.sv */
// Shared widths, constants and item types for the disc time-of-impact core.
package pcoll_pkg;

   // Field and intermediate widths.
   localparam int InW     = 32;   // input field width
   localparam int DifW    = 33;   // relative position or velocity
   localparam int ProdW   = 66;   // product of two differences
   localparam int AW      = 66;   // a = |dv|^2, unsigned
   localparam int HW      = 67;   // h = dv.d, signed
   localparam int CW      = 67;   // c = |d|^2 - contact distance squared, signed
   localparam int MagW    = 66;   // magnitude of h or c
   localparam int HalfW   = 33;   // half of a magnitude, one multiplier operand
   localparam int SqW     = 132;  // h^2 and a*|c|
   localparam int DW      = 132;  // discriminant, unsigned once known nonnegative
   localparam int SW      = 66;   // integer square root of the discriminant
   localparam int NW      = 68;   // numerator before the fraction shift
   localparam int QW      = 32;   // quotient width
   localparam int QDEPTH  = 4;    // entries in the queue between front and back
   localparam int QPW     = 2;    // queue pointer width
   localparam int CntW    = QPW + 1;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;

   // Register map, indexed by paddr[2].
   localparam logic CSR_CONTACT_DIST_SQ = 1'b0;

   // Contact distance squared after reset: 100.0 in Q16.16.
   localparam logic [CsrDataW-1:0] CDS_RESET = 32'd6553600;

   // One input pair.
   typedef struct packed {
      logic signed [InW-1:0] first_pos_x;
      logic signed [InW-1:0] first_pos_y;
      logic signed [InW-1:0] first_vel_x;
      logic signed [InW-1:0] first_vel_y;
      logic signed [InW-1:0] second_pos_x;
      logic signed [InW-1:0] second_pos_y;
      logic signed [InW-1:0] second_vel_x;
      logic signed [InW-1:0] second_vel_y;
   } req_item_type;

   // Classified pair handed from the front to the back.
   typedef struct packed {
      logic [DW-1:0]        disc;   // discriminant, zero when negative
      logic signed [HW-1:0] h;
      logic [AW-1:0]        a;
      logic                 near;   // take the near root
      logic                 nohit;
   } fe_item_type;

endpackage

/* rtl/pcoll_if.sv */
// Valid/ready channel interfaces for input pairs and results.
interface pcoll_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] first_pos_x;
   logic signed [31:0] first_pos_y;
   logic signed [31:0] first_vel_x;
   logic signed [31:0] first_vel_y;
   logic signed [31:0] second_pos_x;
   logic signed [31:0] second_pos_y;
   logic signed [31:0] second_vel_x;
   logic signed [31:0] second_vel_y;

   modport source (
      output valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y,
             second_pos_x, second_pos_y, second_vel_x, second_vel_y,
      input  ready
   );
   modport sink (
      input  valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y,
             second_pos_x, second_pos_y, second_vel_x, second_vel_y,
      output ready
   );
endinterface

interface pcoll_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [31:0] contact_time;

   modport source (output valid, hit, contact_time, input ready);
   modport sink (input valid, hit, contact_time, output ready);
endinterface

/* rtl/pcoll_front.sv */
// Front pipeline: relative motion, quadratic coefficients, discriminant and classification.
module pcoll_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  pcoll_pkg::req_item_type      in_item,
   input  logic [pcoll_pkg::CsrDataW-1:0] cds,
   output logic                         out_valid,
   output pcoll_pkg::fe_item_type       out_item
);
   import pcoll_pkg::*;

   logic [6:0] v_ff;

   // Stage 1: relative position and velocity.
   logic signed [DifW-1:0] dx_ff, dy_ff, dvx_ff, dvy_ff;
   // Stage 2: products.
   logic signed [ProdW-1:0] pvvx_ff, pvvy_ff, pvdx_ff, pvdy_ff, pddx_ff, pddy_ff;
   // Stage 3: coefficients.
   logic [AW-1:0]        a3_ff;
   logic signed [HW-1:0] h3_ff;
   logic signed [CW-1:0] c3_ff;
   // Stage 4: magnitudes and signs.
   logic [AW-1:0]        a4_ff;
   logic signed [HW-1:0] h4_ff;
   logic [MagW-1:0]      hmag_ff, cmag_ff;
   logic                 azero4_ff, hnonpos4_ff, cneg4_ff, czero4_ff;
   // Stage 5: partial products.
   logic [ProdW-1:0]     hhh_ff, hhl_ff, hll_ff, ahch_ff, ahcl_ff, alch_ff, alcl_ff;
   logic [AW-1:0]        a5_ff;
   logic signed [HW-1:0] h5_ff;
   logic                 azero5_ff, hnonpos5_ff, cneg5_ff, czero5_ff;
   // Stage 6: h^2 and a*|c|.
   logic [SqW-1:0]       hsq_ff, ac_ff;
   logic [AW-1:0]        a6_ff;
   logic signed [HW-1:0] h6_ff;
   logic                 azero6_ff, hnonpos6_ff, cneg6_ff, czero6_ff;
   // Stage 7: classified item.
   fe_item_type          item_ff;

   logic signed [CW-1:0] rsq;
   logic [SqW-1:0]       hsq_in, ac_in;
   logic signed [DW:0]   d_full;
   logic                 d_neg;

   assign rsq = CW'($signed({1'b0, cds, {FRAC_BITS{1'b0}}}));

   // Squares and cross terms rebuilt from their 33-bit halves.
   assign hsq_in = (SqW'(hhh_ff) << (2 * HalfW)) + (SqW'(hhl_ff) << (HalfW + 1))
                 + SqW'(hll_ff);
   assign ac_in  = (SqW'(ahch_ff) << (2 * HalfW))
                 + ((SqW'(ahcl_ff) + SqW'(alch_ff)) << HalfW) + SqW'(alcl_ff);

   // Discriminant h^2 - a*c, with the sign of c folded in.
   assign d_full = cneg6_ff ? $signed((DW + 1)'(hsq_ff) + (DW + 1)'(ac_ff))
                            : $signed((DW + 1)'(hsq_ff) - (DW + 1)'(ac_ff));
   assign d_neg  = d_full[DW];

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff   <= DifW'(in_item.second_pos_x) - DifW'(in_item.first_pos_x);
         dy_ff   <= DifW'(in_item.second_pos_y) - DifW'(in_item.first_pos_y);
         dvx_ff  <= DifW'(in_item.second_vel_x) - DifW'(in_item.first_vel_x);
         dvy_ff  <= DifW'(in_item.second_vel_y) - DifW'(in_item.first_vel_y);

         pvvx_ff <= dvx_ff * dvx_ff;
         pvvy_ff <= dvy_ff * dvy_ff;
         pvdx_ff <= dvx_ff * dx_ff;
         pvdy_ff <= dvy_ff * dy_ff;
         pddx_ff <= dx_ff * dx_ff;
         pddy_ff <= dy_ff * dy_ff;

         a3_ff <= AW'($unsigned(pvvx_ff)) + AW'($unsigned(pvvy_ff));
         h3_ff <= HW'(pvdx_ff) + HW'(pvdy_ff);
         c3_ff <= CW'(pddx_ff) + CW'(pddy_ff) - rsq;

         a4_ff       <= a3_ff;
         h4_ff       <= h3_ff;
         hmag_ff     <= h3_ff[HW-1] ? MagW'(-h3_ff) : MagW'(h3_ff);
         cmag_ff     <= c3_ff[CW-1] ? MagW'(-c3_ff) : MagW'(c3_ff);
         azero4_ff   <= (a3_ff == '0);
         hnonpos4_ff <= h3_ff[HW-1] || (h3_ff == '0);
         cneg4_ff    <= c3_ff[CW-1];
         czero4_ff   <= (c3_ff == '0);

         hhh_ff <= hmag_ff[MagW-1:HalfW] * hmag_ff[MagW-1:HalfW];
         hhl_ff <= hmag_ff[MagW-1:HalfW] * hmag_ff[HalfW-1:0];
         hll_ff <= hmag_ff[HalfW-1:0] * hmag_ff[HalfW-1:0];
         ahch_ff <= a4_ff[AW-1:HalfW] * cmag_ff[MagW-1:HalfW];
         ahcl_ff <= a4_ff[AW-1:HalfW] * cmag_ff[HalfW-1:0];
         alch_ff <= a4_ff[HalfW-1:0] * cmag_ff[MagW-1:HalfW];
         alcl_ff <= a4_ff[HalfW-1:0] * cmag_ff[HalfW-1:0];
         a5_ff       <= a4_ff;
         h5_ff       <= h4_ff;
         azero5_ff   <= azero4_ff;
         hnonpos5_ff <= hnonpos4_ff;
         cneg5_ff    <= cneg4_ff;
         czero5_ff   <= czero4_ff;

         hsq_ff      <= hsq_in;
         ac_ff       <= ac_in;
         a6_ff       <= a5_ff;
         h6_ff       <= h5_ff;
         azero6_ff   <= azero5_ff;
         hnonpos6_ff <= hnonpos5_ff;
         cneg6_ff    <= cneg5_ff;
         czero6_ff   <= czero5_ff;

         // No contact when the discs do not move relative to each other,
         // when the path misses, or when both roots lie in the past.
         item_ff.disc  <= d_neg ? '0 : d_full[DW-1:0];
         item_ff.h     <= h6_ff;
         item_ff.a     <= a6_ff;
         item_ff.near  <= hnonpos6_ff && !cneg6_ff;
         item_ff.nohit <= azero6_ff || d_neg || (!hnonpos6_ff && !cneg6_ff && !czero6_ff);
      end
   end

   assign out_valid = v_ff[6];
   assign out_item  = item_ff;

endmodule

/* rtl/pcoll_queue.sv */
// Short queue that decouples the front pipeline from the back pipeline.
module pcoll_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pcoll_pkg::fe_item_type push_item,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output pcoll_pkg::fe_item_type head_item
);
   import pcoll_pkg::*;

   fe_item_type      q_ff [QDEPTH];
   logic [QPW-1:0]   wptr_ff, rptr_ff;
   logic [CntW-1:0]  count_ff;

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         count_ff <= count_ff + CntW'(push) - CntW'(pop);
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= push_item;
      end
   end

   assign full       = (count_ff == CntW'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = q_ff[rptr_ff];

endmodule

/* rtl/pcoll_back.sv */
// Back pipeline: square root, root selection, saturating divide and result register.
module pcoll_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  pcoll_pkg::fe_item_type in_item,
   output logic                   in_pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic                   out_hit,
   output logic [pcoll_pkg::QW-1:0] out_time
);
   import pcoll_pkg::*;

   localparam int RW   = SW + 1;
   localparam int TW   = SW + 3;
   localparam int XW   = NW + FRAC_BITS;
   localparam int HIW  = XW - QW;
   localparam int CMPW = (HIW > AW) ? HIW : AW;

   logic en;

   // Square root stages, one result bit each.
   logic                 sv_ff     [SW];
   logic [DW-1:0]        sd_ff     [SW];
   logic [RW-1:0]        srem_ff   [SW];
   logic [SW-1:0]        sroot_ff  [SW];
   logic signed [HW-1:0] sh_ff     [SW];
   logic [AW-1:0]        sa_ff     [SW];
   logic                 snear_ff  [SW];
   logic                 snohit_ff [SW];

   // Numerator stage.
   logic            nv_ff, nnohit_ff;
   logic [NW-1:0]   n_ff;
   logic [AW-1:0]   na_ff;

   // Saturation check stage.
   logic            tv_ff, tsat_ff, tnohit_ff;
   logic [AW-1:0]   trem_ff, ta_ff;
   logic [QW-1:0]   txlo_ff;

   // Divide stages, one quotient bit each.
   logic            dv_ff     [QW];
   logic [AW-1:0]   drem_ff   [QW];
   logic [QW-1:0]   dq_ff     [QW];
   logic [QW-1:0]   dxlo_ff   [QW];
   logic [AW-1:0]   da_ff     [QW];
   logic            dsat_ff   [QW];
   logic            dnohit_ff [QW];

   // Result register.
   logic            ov_ff, ohit_ff;
   logic [QW-1:0]   otime_ff;

   // The whole back pipeline advances unless a result is held.
   assign en     = !ov_ff || out_ready;
   assign in_pop = en && in_valid;

   for (genvar k = 0; k < SW; k++) begin : g_sqrt
      logic                 v_src, near_src, nohit_src, ge;
      logic [DW-1:0]        d_src;
      logic [RW-1:0]        rem_src;
      logic [SW-1:0]        root_src;
      logic signed [HW-1:0] h_src;
      logic [AW-1:0]        a_src;
      logic [TW-1:0]        tmp, trial;

      if (k == 0) begin : g_head
         assign v_src     = in_valid;
         assign d_src     = in_item.disc;
         assign rem_src   = '0;
         assign root_src  = '0;
         assign h_src     = in_item.h;
         assign a_src     = in_item.a;
         assign near_src  = in_item.near;
         assign nohit_src = in_item.nohit;
      end else begin : g_body
         assign v_src     = sv_ff[k-1];
         assign d_src     = sd_ff[k-1];
         assign rem_src   = srem_ff[k-1];
         assign root_src  = sroot_ff[k-1];
         assign h_src     = sh_ff[k-1];
         assign a_src     = sa_ff[k-1];
         assign near_src  = snear_ff[k-1];
         assign nohit_src = snohit_ff[k-1];
      end

      // Bring down the next two bits and try appending a one to the root.
      assign tmp   = {rem_src, d_src[DW-1 -: 2]};
      assign trial = {1'b0, root_src, 2'b01};
      assign ge    = (tmp >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k] <= 1'b0;
         end else if (en) begin
            sv_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sd_ff[k]     <= {d_src[DW-3:0], 2'b00};
            srem_ff[k]   <= ge ? RW'(tmp - trial) : RW'(tmp);
            sroot_ff[k]  <= {root_src[SW-2:0], ge};
            sh_ff[k]     <= h_src;
            sa_ff[k]     <= a_src;
            snear_ff[k]  <= near_src;
            snohit_ff[k] <= nohit_src;
         end
      end
   end

   // Root numerator: -h - s for the near root, s - h for the far root.
   logic signed [NW:0] hx, sx, nval;
   assign hx   = (NW + 1)'(sh_ff[SW-1]);
   assign sx   = $signed((NW + 1)'(sroot_ff[SW-1]));
   assign nval = snear_ff[SW-1] ? (-hx - sx) : (sx - hx);

   // Scale the numerator and check for a quotient beyond 32 bits.
   logic [XW-1:0]  xval;
   logic [HIW-1:0] xhi;
   logic           sat;
   assign xval = {n_ff, {FRAC_BITS{1'b0}}};
   assign xhi  = xval[XW-1:QW];
   assign sat  = (CMPW'(xhi) >= CMPW'(na_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= 1'b0;
         tv_ff <= 1'b0;
      end else if (en) begin
         nv_ff <= sv_ff[SW-1];
         tv_ff <= nv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff      <= nval[NW-1:0];
         na_ff     <= sa_ff[SW-1];
         nnohit_ff <= snohit_ff[SW-1];

         trem_ff   <= AW'(xhi);
         txlo_ff   <= xval[QW-1:0];
         ta_ff     <= na_ff;
         tsat_ff   <= sat;
         tnohit_ff <= nnohit_ff;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      logic            v_src, sat_src, nohit_src, ge;
      logic [AW-1:0]   rem_src, a_src;
      logic [QW-1:0]   q_src, xlo_src;
      logic [AW:0]     tmp;

      if (k == 0) begin : g_head
         assign v_src     = tv_ff;
         assign rem_src   = trem_ff;
         assign q_src     = '0;
         assign xlo_src   = txlo_ff;
         assign a_src     = ta_ff;
         assign sat_src   = tsat_ff;
         assign nohit_src = tnohit_ff;
      end else begin : g_body
         assign v_src     = dv_ff[k-1];
         assign rem_src   = drem_ff[k-1];
         assign q_src     = dq_ff[k-1];
         assign xlo_src   = dxlo_ff[k-1];
         assign a_src     = da_ff[k-1];
         assign sat_src   = dsat_ff[k-1];
         assign nohit_src = dnohit_ff[k-1];
      end

      // Restoring division step on the next numerator bit.
      assign tmp = {rem_src, xlo_src[QW-1-k]};
      assign ge  = (tmp >= {1'b0, a_src});

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else if (en) begin
            dv_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            drem_ff[k]   <= ge ? AW'(tmp - {1'b0, a_src}) : AW'(tmp);
            dq_ff[k]     <= {q_src[QW-2:0], ge};
            dxlo_ff[k]   <= xlo_src;
            da_ff[k]     <= a_src;
            dsat_ff[k]   <= sat_src;
            dnohit_ff[k] <= nohit_src;
         end
      end
   end

   // Result register; holds while the consumer stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= dv_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ohit_ff  <= !dnohit_ff[QW-1];
         otime_ff <= dnohit_ff[QW-1] ? '0 : (dsat_ff[QW-1] ? '1 : dq_ff[QW-1]);
      end
   end

   assign out_valid = ov_ff;
   assign out_hit   = ohit_ff;
   assign out_time  = otime_ff;

endmodule

/* rtl/pairwise_collision_time_core.sv */
// Throughput: one disc pair per clock cycle while results are taken.
// Path from input transfer to result offered: 7 front stages, the queue,
// 66 square-root stages, numerator, range check, 32 quotient stages, result register.
// The 4-entry queue lets the front keep accepting for a while when results stall.
// Reset (synchronous) empties the pipelines and the queue and sets the contact
// distance squared to 100.0.
module pairwise_collision_time_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   pcoll_req_if.sink                      req_chan,
   pcoll_rsp_if.source                    rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pcoll_pkg::CsrAddrW-1:0] paddr,
   input  logic [pcoll_pkg::CsrDataW-1:0] pwdata,
   output logic [pcoll_pkg::CsrDataW-1:0] prdata,
   output logic                           pready
);
   import pcoll_pkg::*;

   logic [CsrDataW-1:0] cds_ff;
   req_item_type        req_item;
   logic                front_en, f_valid, q_full, q_push, q_pop, q_valid;
   fe_item_type         f_item, q_item;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cds_ff <= CDS_RESET;
      end else if (psel && penable && pwrite && paddr[CsrAddrW-1] == CSR_CONTACT_DIST_SQ) begin
         cds_ff <= pwdata;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[CsrAddrW-1] == CSR_CONTACT_DIST_SQ) ? cds_ff : '0;

   assign req_item.first_pos_x  = req_chan.first_pos_x;
   assign req_item.first_pos_y  = req_chan.first_pos_y;
   assign req_item.first_vel_x  = req_chan.first_vel_x;
   assign req_item.first_vel_y  = req_chan.first_vel_y;
   assign req_item.second_pos_x = req_chan.second_pos_x;
   assign req_item.second_pos_y = req_chan.second_pos_y;
   assign req_item.second_vel_x = req_chan.second_vel_x;
   assign req_item.second_vel_y = req_chan.second_vel_y;

   // The front stalls only when its last stage cannot enter a full queue.
   assign front_en       = !(f_valid && q_full);
   assign q_push         = f_valid && !q_full;
   assign req_chan.ready = front_en;

   pcoll_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (front_en),
      .in_valid  (req_chan.valid),
      .in_item   (req_item),
      .cds       (cds_ff),
      .out_valid (f_valid),
      .out_item  (f_item)
   );

   pcoll_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (f_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (q_item)
   );

   pcoll_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_item   (q_item),
      .in_pop    (q_pop),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_hit   (rsp_chan.hit),
      .out_time  (rsp_chan.contact_time)
   );

endmodule

/* rtl/pcoll_checker.sv */
// Port-level checks for the time-of-impact core, bound to the top level.
module pcoll_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [31:0] rsp_time,
   input logic        psel,
   input logic        penable,
   input logic        pwrite,
   input logic [2:0]  paddr,
   input logic [31:0] pwdata,
   input logic [31:0] prdata
);

   // No result is offered right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_time))
      else $error("stalled result changed");

   // A miss always reports time zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_time == 32'd0)
      else $error("miss with nonzero contact time");

   // A written contact distance reads back on the next cycle.
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr[2] == 1'b0)
      ##1 (psel && !pwrite && paddr[2] == 1'b0) |-> prdata == $past(pwdata))
      else $error("contact distance readback mismatch");

endmodule

bind pairwise_collision_time_core pcoll_checker u_pcoll_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_hit   (rsp_chan.hit),
   .rsp_time  (rsp_chan.contact_time),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata)
);

/* test/pcoll_checker.sv */
// Result checker for the disc time-of-impact core: predicts each result and compares it.
module pcoll_scoreboard (
   input  logic        clock,
   input  logic        reset,
   pcoll_req_if        req_chan,
   pcoll_rsp_if        rsp_chan,
   input  logic [31:0] contact_dist_sq,
   output int          fail_count,
   output int          pending_count
);
   import pcoll_pkg::*;

   typedef struct packed {
      logic        hit;
      logic [31:0] contact_time;
   } impact_type;

   impact_type impact_queue[$];
   int mismatch_count;

   // Floor of the square root of a nonnegative value, bit by bit.
   function automatic logic [255:0] isqrt256(logic [255:0] d);
      logic [255:0] r;
      logic [255:0] c;
      r = '0;
      for (int b = 127; b >= 0; b--) begin
         c = r | (256'd1 << b);
         if (c * c <= d) r = c;
      end
      return r;
   endfunction

   // Earliest contact time of one disc pair, computed exactly in 256-bit arithmetic.
   function automatic impact_type predict_impact(req_item_type p, logic [31:0] cds);
      logic signed [255:0] dx, dy, dvx, dvy, a, h, c, d, s, n, q;
      impact_type res;
      dx  = 256'(signed'(p.second_pos_x)) - 256'(signed'(p.first_pos_x));
      dy  = 256'(signed'(p.second_pos_y)) - 256'(signed'(p.first_pos_y));
      dvx = 256'(signed'(p.second_vel_x)) - 256'(signed'(p.first_vel_x));
      dvy = 256'(signed'(p.second_vel_y)) - 256'(signed'(p.first_vel_y));
      a = dvx * dvx + dvy * dvy;
      h = dvx * dx + dvy * dy;
      c = dx * dx + dy * dy - (256'(cds) << 16);
      d = h * h - a * c;
      res = '0;
      if (a == 0 || d < 0) return res;
      s = isqrt256(d);
      if (h <= 0 && c >= 0) n = -h - s;
      else if (h <= 0 || c <= 0) n = s - h;
      else return res;
      q = (n << 16) / a;
      res.hit = 1'b1;
      res.contact_time = (q >>> 32) != 0 ? 32'hFFFF_FFFF : q[31:0];
      return res;
   endfunction

   assign pending_count = impact_queue.size();
   assign fail_count = mismatch_count;

   // Predict on every input transfer and compare on every result transfer.
   always @(posedge clock) begin
      req_item_type p;
      impact_type want;
      if (reset) begin
         impact_queue.delete();
         mismatch_count <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            p = {req_chan.first_pos_x, req_chan.first_pos_y, req_chan.first_vel_x,
                 req_chan.first_vel_y, req_chan.second_pos_x, req_chan.second_pos_y,
                 req_chan.second_vel_x, req_chan.second_vel_y};
            impact_queue.insert(impact_queue.size(), predict_impact(p, contact_dist_sq));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (impact_queue.size() == 0) begin
               if (mismatch_count < 10) $display("unexpected result transfer");
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = impact_queue.pop_front();
               if (want.hit !== rsp_chan.hit || want.contact_time !== rsp_chan.contact_time)
               begin
                  if (mismatch_count < 10)
                     $display("mismatch: expected hit %0b time %h, got hit %0b time %h",
                              want.hit, want.contact_time, rsp_chan.hit,
                              rsp_chan.contact_time);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end
endmodule

/* test/tb_top.sv */
// Top of the disc time-of-impact testbench: clock, reset, stimulus and verdict.
module tb_top;
   import pcoll_pkg::*;

   localparam logic [2:0] ADDR_CDS = 3'd0;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        pready;
   logic [31:0] cds_model;
   logic        in_quiet;
   int          fail_count, pending_count, leftover;

   pcoll_req_if req_chan ();
   pcoll_rsp_if rsp_chan ();

   pairwise_collision_time_core DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   pcoll_scoreboard checker_inst (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .contact_dist_sq(cds_model), .fail_count(fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run.
   initial begin
      #5000000;
      $display("tb_top failed");
      $finish;
   end

   // Result side stalls in random bursts, except in the quiet tail.
   initial begin
      int n;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!in_quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 17);
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   // Random 32-bit value, often an extreme or small.
   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic csr_write(logic [31:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ADDR_CDS;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      cds_model <= value;
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every result is back and the pipeline is drained.
   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   // Send one pair, with an optional idle burst first.
   task automatic send_pair(logic [31:0] f[8]);
      if (!in_quiet && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.first_pos_x <= f[0]; req_chan.first_pos_y <= f[1];
      req_chan.first_vel_x <= f[2]; req_chan.first_vel_y <= f[3];
      req_chan.second_pos_x <= f[4]; req_chan.second_pos_y <= f[5];
      req_chan.second_vel_x <= f[6]; req_chan.second_vel_y <= f[7];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Geometric pair: small discs with a chance of contact.
   task automatic send_scene();
      logic [31:0] f[8];
      for (int i = 0; i < 8; i++)
         f[i] = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      if ($urandom_range(0, 1)) begin
         f[6] = -f[4] >>> 3; f[7] = -f[5] >>> 3; f[2] = 0; f[3] = 0;
         f[0] = 0; f[1] = 0;
      end
      send_pair(f);
   endtask

   initial begin
      logic [31:0] f[8];
      logic [31:0] settings[6];
      reset = 1'b1; in_quiet = 1'b0;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      cds_model = CDS_RESET;
      req_chan.valid = 1'b0;
      req_chan.first_pos_x = 0; req_chan.first_pos_y = 0;
      req_chan.first_vel_x = 0; req_chan.first_vel_y = 0;
      req_chan.second_pos_x = 0; req_chan.second_pos_y = 0;
      req_chan.second_vel_x = 0; req_chan.second_vel_y = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pairs, then pairs of random fields, at the reset contact distance.
      for (int k = 0; k < 20; k++) begin
         for (int i = 0; i < 8; i++) f[i] = 0;
         case (k)
            0: ;                                          // zero relative speed
            1: begin f[4] = 32'h0014_0000; f[6] = 32'hFFFF_0000; end   // approaching
            2: begin f[4] = 32'h0014_0000; f[6] = 32'h0001_0000; end   // receding
            3: begin f[4] = 32'h0002_0000; f[6] = 32'h0001_0000; end   // overlapping
            4: begin f[4] = 32'h000A_0000; f[6] = 32'h0001_0000; end   // touching now
            5: begin f[4] = 32'h0014_0000; f[5] = 32'h0014_0000;
                     f[6] = 32'hFFFF_0000; end                          // miss
            6: begin f[4] = 32'h7FFF_FFFF; f[6] = 32'h0000_0001; f[2] = 32'h0000_0002; end
            7: begin f[0] = 32'h7FFF_FFFF; f[4] = 32'h8000_0000;
                     f[2] = 32'h8000_0000; f[6] = 32'h7FFF_FFFF; end
            8: for (int i = 0; i < 8; i++) f[i] = (i < 4) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            9: for (int i = 0; i < 8; i++) f[i] = (i < 4) ? 32'h7FFF_FFFF : 32'h8000_0000;
            10: for (int i = 0; i < 8; i++) f[i] = 32'hFFFF_FFFF;
            default: for (int i = 0; i < 8; i++) f[i] = rand_field();
         endcase
         send_pair(f);
      end
      req_chan.valid <= 1'b0;
      drain();

      // Random phases over several contact distances.
      settings = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0000_4000, 32'h0640_0000, 32'h8000_0000};
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(ph == 5 ? $urandom : settings[ph]);
         if (ph == 5) in_quiet = 1'b1;
         for (int k = 0; k < 240; k++) begin
            if ($urandom_range(0, 3) == 0) begin
               for (int i = 0; i < 8; i++) f[i] = rand_field();
               send_pair(f);
            end else begin
               send_scene();
            end
         end
         req_chan.valid <= 1'b0;
         drain();
      end

      leftover = pending_count;
      if (fail_count == 0 && leftover == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule
